// ===== design/iep_pkg.sv =====
`default_nettype none

package iep_pkg;

    // Arithmetic width of the evaluator and of the result port
    localparam int DATA_W  = 32;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DATA_W);

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // Pending operator
    typedef enum logic [1:0] {
        OP_PLUS  = 2'd0,
        OP_MINUS = 2'd1,
        OP_TIMES = 2'd2,
        OP_DIV   = 2'd3
    } t_op;

    // Request and response between the control and the serial mul/div unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    typedef struct packed {
        logic done;
    } t_md_rsp;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_TIMES) || (c == CH_DIV);
    endfunction

    function automatic t_op op_of(input logic [7:0] c);
        t_op op;
        case (c)
            CH_PLUS:  op = OP_PLUS;
            CH_MINUS: op = OP_MINUS;
            CH_TIMES: op = OP_TIMES;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

    // Magnitude of a two's complement value (most negative maps to itself)
    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== design/iep_muldiv.sv =====
`default_nettype none

// Bit-serial multiply (low half) and signed restoring divide, one bit per cycle
module iep_muldiv import iep_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_md_req           i_req,
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    output t_md_rsp                o_rsp,
    output logic      [DATA_W-1:0] o_res
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} t_mstate;

    t_mstate           r_state;
    logic              r_div;
    logic              r_neg;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_p;     // product accumulator / partial remainder
    logic [DATA_W-1:0] r_q;     // multiplier / dividend, quotient shifts in
    logic [DATA_W-1:0] r_d;     // multiplicand / divisor magnitude
    logic [DATA_W-1:0] r_res;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_padd;

    // One divide step: shift remainder, trial subtract
    assign w_shift = {r_p, r_q[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};
    // One multiply step
    assign w_padd  = r_p + r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_div <= i_req.is_div;
                        r_cnt <= '0;
                        r_p   <= '0;
                        if (i_req.is_div) begin
                            r_q   <= magnitude(i_a);
                            r_d   <= magnitude(i_b);
                            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                        end else begin
                            r_q   <= i_b;
                            r_d   <= i_a;
                            r_neg <= 1'b0;
                        end
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (r_div) begin
                        if (!w_diff[DATA_W]) begin
                            r_p <= w_diff[DATA_W-1:0];
                            r_q <= {r_q[DATA_W-2:0], 1'b1};
                        end else begin
                            r_p <= w_shift[DATA_W-1:0];
                            r_q <= {r_q[DATA_W-2:0], 1'b0};
                        end
                    end else begin
                        if (r_q[0]) begin
                            r_p <= w_padd;
                        end
                        r_d <= {r_d[DATA_W-2:0], 1'b0};
                        r_q <= {1'b0, r_q[DATA_W-1:1]};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_state <= M_FIX;
                    end
                end
                M_FIX: begin
                    // quotient sign fix, or pass the product
                    if (r_div) begin
                        r_res <= r_neg ? (~r_q + 1'b1) : r_q;
                    end else begin
                        r_res <= r_p;
                    end
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_res      = r_res;

endmodule

`default_nettype wire

// ===== design/infix_expression_evaluator.sv =====
`default_nettype none

// Channel   Valid     Ready     Beat fields
// input     i_valid   o_ready   i_char_code[7:0], i_end_of_expr
// output    o_valid   i_ready   o_value[31:0] (signed), o_div_zero
//
// Digits and ignored characters are taken in the idle state; an operator after a pending + or - adds an apply.
// An operator after a pending * or / (unless it divides by zero) runs the one-bit-per-step
// mul/div unit: apply, one step per bit, sign fix, result handoff.
// The last beat adds a flush apply and a sum state that forms the sum.
// Input is taken while a result waits in the output register; the sum cycle stalls until it drains.
// Reset is synchronous, active low, and clears all expression state.
module infix_expression_evaluator import iep_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_end_of_expr,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                    o_div_zero
);

    typedef enum logic [1:0] {S_IDLE, S_APPLY, S_MDWAIT, S_SUM} t_state;

    t_state            r_state, n_state;
    t_op               r_pend, n_pend;
    t_op               r_next_op, n_next_op;
    logic              r_last, n_last;
    logic              r_fin, n_fin;
    logic              r_err;
    logic [DATA_W-1:0] r_sum;
    logic [DATA_W-1:0] r_term;
    logic [DATA_W-1:0] r_cur;
    logic              r_ovalid;
    logic [VALUE_W-1:0] r_ovalue;
    logic              r_odz;

    logic              w_accept;
    logic              w_additive;
    logic              w_dz;
    logic              w_apply_done;
    logic              w_load;
    logic [DATA_W-1:0] w_digit_next;
    logic [DATA_W-1:0] w_total;
    t_md_req           w_md_req;
    t_md_rsp           w_md_rsp;
    logic [DATA_W-1:0] w_md_res;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Decimal accumulate: cur*10 + digit
    assign w_digit_next = {r_cur[DATA_W-4:0], 3'b000} + {r_cur[DATA_W-2:0], 1'b0}
                        + DATA_W'(i_char_code - CH_ZERO);

    assign w_additive = (r_pend == OP_PLUS) || (r_pend == OP_MINUS);
    assign w_dz       = (r_pend == OP_DIV) && (r_cur == '0);
    assign w_total    = r_sum + r_term;

    // Sum state hands a result over once the output register is free
    assign w_load = (r_state == S_SUM) && (!r_ovalid || i_ready);

    // Serial unit handles pending * and /
    assign w_md_req.start  = (r_state == S_APPLY) && !w_additive && !w_dz;
    assign w_md_req.is_div = (r_pend == OP_DIV);

    iep_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .i_a     (r_term),
        .i_b     (r_cur),
        .o_rsp   (w_md_rsp),
        .o_res   (w_md_res)
    );

    assign w_apply_done = ((r_state == S_APPLY) && (w_additive || w_dz))
                       || ((r_state == S_MDWAIT) && w_md_rsp.done);

    // Sequencing after an apply: maybe a flush apply, then the sum
    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_next_op = r_next_op;
        n_last    = r_last;
        n_fin     = r_fin;
        if (w_apply_done) begin
            n_pend = r_next_op;
            if (r_last) begin
                n_last    = 1'b0;
                n_fin     = 1'b1;
                n_next_op = OP_PLUS;
                n_state   = S_APPLY;
            end else if (r_fin) begin
                n_state = S_SUM;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= OP_PLUS;
            r_next_op <= OP_PLUS;
            r_last    <= 1'b0;
            r_fin     <= 1'b0;
            r_err     <= 1'b0;
            r_sum     <= '0;
            r_term    <= '0;
            r_cur     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // output register: load from the sum state, else drain on accept
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (is_digit(i_char_code)) begin
                            r_cur <= w_digit_next;
                        end
                        if (is_oper(i_char_code)) begin
                            r_next_op <= op_of(i_char_code);
                            r_last    <= i_end_of_expr;
                            r_fin     <= 1'b0;
                            r_state   <= S_APPLY;
                        end else if (i_end_of_expr) begin
                            r_next_op <= OP_PLUS;
                            r_last    <= 1'b0;
                            r_fin     <= 1'b1;
                            r_state   <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    if (w_additive) begin
                        r_sum  <= w_total;
                        r_term <= (r_pend == OP_MINUS) ? (~r_cur + 1'b1) : r_cur;
                    end else if (w_dz) begin
                        r_err <= 1'b1;
                    end
                    r_cur <= '0;
                    if (!w_apply_done) begin
                        r_state <= S_MDWAIT;
                    end else begin
                        r_state   <= n_state;
                        r_pend    <= n_pend;
                        r_next_op <= n_next_op;
                        r_last    <= n_last;
                        r_fin     <= n_fin;
                    end
                end
                S_MDWAIT: begin
                    if (w_apply_done) begin
                        r_term    <= w_md_res;
                        r_state   <= n_state;
                        r_pend    <= n_pend;
                        r_next_op <= n_next_op;
                        r_last    <= n_last;
                        r_fin     <= n_fin;
                    end
                end
                S_SUM: begin
                    // load output register once it is free, then clear
                    if (w_load) begin
                        r_ovalue  <= r_err ? '0 : VALUE_W'($signed(w_total));
                        r_odz     <= r_err;
                        r_state   <= S_IDLE;
                        r_pend    <= OP_PLUS;
                        r_next_op <= OP_PLUS;
                        r_last    <= 1'b0;
                        r_fin     <= 1'b0;
                        r_err     <= 1'b0;
                        r_sum     <= '0;
                        r_term    <= '0;
                        r_cur     <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_value    = r_ovalue;
    assign o_div_zero = r_odz;

    // A mul/div result only arrives while the control waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_rsp.done |-> (r_state == S_MDWAIT))
        else $error("mul/div done outside wait state");

    // A flagged result carries a zero value
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_value == '0))
        else $error("divide-by-zero result not zero");

    // A new result is loaded only from the sum state
    a_load_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_SUM))
        else $error("result loaded outside sum state");

    // A non-final digit keeps the block ready
    a_digit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && is_digit(i_char_code) && !i_end_of_expr) |=> o_ready)
        else $error("digit beat left block busy");

endmodule

`default_nettype wire
